FILE: hw/rtl/hbx_pkg.sv
// shared types, character codes and helper functions for the body extractor
package hbx_pkg;

    // size counter width default
    localparam int SIZE_BITS_DEF = 32;

    // configuration port geometry and register index
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_CHUNKED_MODE = 1'b0;

    // character codes
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_X_LO   = 8'h78;

    // input and result words
    typedef struct packed {
        logic [7:0] request_byte;
        logic       end_of_request;
    } t_in_word;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       end_of_body;
    } t_out_word;

    // chunk framing phase
    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP
    } t_chunk_phase;

    // size line number parsing phase
    typedef enum logic [1:0] {
        HX_BLANK,
        HX_ZERO,
        HX_DIGITS,
        HX_DONE
    } t_hex_phase;

    // whitespace accepted before the size digits
    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    // hex digit check
    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
               ((b >= CH_A_LO) && (b <= CH_F_LO)) ||
               ((b >= CH_A_UP) && (b <= CH_F_UP));
    endfunction

    // hex digit value, letters map to 10..15
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        if ((b >= CH_ZERO) && (b <= CH_NINE)) begin
            v = b - CH_ZERO;
        end else if ((b >= CH_A_LO) && (b <= CH_F_LO)) begin
            v = b - CH_A_LO + 8'd10;
        end else begin
            v = b - CH_A_UP + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

FILE: hw/rtl/hbx_regs.sv
// configuration register block with apb-style access
module hbx_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbx_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbx_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic                           o_chunked_mode
);
    import hbx_pkg::*;

    logic r_chunked_mode;
    logic hit;
    logic wr_en;

    // address decode
    assign hit   = (paddr[APB_ADDR_W-1:2] == REG_CHUNKED_MODE);
    assign wr_en = psel && penable && pwrite && hit;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunked_mode <= 1'b0;
        end else if (wr_en) begin
            r_chunked_mode <= pwdata[0];
        end
    end

    // read back
    assign prdata = hit ? {{(APB_DATA_W-1){1'b0}}, r_chunked_mode} : '0;
    assign pready = 1'b1;
    assign o_chunked_mode = r_chunked_mode;

endmodule

FILE: hw/rtl/hbx_parser.sv
// per-byte header skip and chunk framing state machine
module hbx_parser #(
    parameter int SIZE_BITS = hbx_pkg::SIZE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  hbx_pkg::t_in_word  i_word,
    input  logic               i_mode,
    output hbx_pkg::t_out_word o_result,
    output logic               o_has_result
);
    import hbx_pkg::*;

    logic [1:0]           r_hdr_cnt,   n_hdr_cnt;
    logic                 r_in_body,   n_in_body;
    t_chunk_phase         r_phase,     n_phase;
    t_hex_phase           r_hex,       n_hex;
    logic [SIZE_BITS-1:0] r_count,     n_count;
    logic                 r_prev_cr,   n_prev_cr;
    logic [1:0]           r_skip_left, n_skip_left;

    logic [7:0]           b;
    logic                 dig_ok;
    logic [3:0]           dig;
    logic [SIZE_BITS-1:0] count_add;
    logic                 valid;

    assign b      = i_word.request_byte;
    assign dig_ok = is_hex(b);
    assign dig    = hex_val(b);

    // shift in one hex digit, saturating at all ones
    assign count_add = (|r_count[SIZE_BITS-1 -: 4]) ? '1 :
                       {r_count[SIZE_BITS-5:0], dig};

    // next state
    always_comb begin
        n_hdr_cnt   = r_hdr_cnt;
        n_in_body   = r_in_body;
        n_phase     = r_phase;
        n_hex       = r_hex;
        n_count     = r_count;
        n_prev_cr   = r_prev_cr;
        n_skip_left = r_skip_left;
        if (!r_in_body) begin
            // hunt for the blank line that ends the header
            if (b == CH_CR) begin
                n_hdr_cnt = (r_hdr_cnt == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == CH_LF) begin
                if (r_hdr_cnt == 2'd1) begin
                    n_hdr_cnt = 2'd2;
                end else if (r_hdr_cnt == 2'd3) begin
                    n_in_body = 1'b1;
                    n_hdr_cnt = 2'd0;
                end else begin
                    n_hdr_cnt = 2'd0;
                end
            end else begin
                n_hdr_cnt = 2'd0;
            end
        end else if (i_mode) begin
            unique case (r_phase)
                PH_SIZE: begin
                    if (r_prev_cr && (b == CH_LF)) begin
                        // size line complete
                        n_prev_cr = 1'b0;
                        n_hex     = HX_BLANK;
                        if (r_count != '0) begin
                            n_phase = PH_DATA;
                        end else begin
                            n_phase     = PH_SKIP;
                            n_skip_left = 2'd2;
                        end
                    end else begin
                        n_prev_cr = (b == CH_CR);
                        case (r_hex)
                            HX_BLANK: begin
                                if (is_blank(b)) begin
                                    n_hex = HX_BLANK;
                                end else if (b == CH_ZERO) begin
                                    n_count = '0;
                                    n_hex   = HX_ZERO;
                                end else if (dig_ok) begin
                                    n_count = SIZE_BITS'(dig);
                                    n_hex   = HX_DIGITS;
                                end else begin
                                    n_hex = HX_DONE;
                                end
                            end
                            HX_ZERO: begin
                                if ((b == CH_X_LO) || (b == CH_X_UP)) begin
                                    n_hex = HX_DIGITS;
                                end else if (dig_ok) begin
                                    n_count = count_add;
                                    n_hex   = HX_DIGITS;
                                end else begin
                                    n_hex = HX_DONE;
                                end
                            end
                            HX_DIGITS: begin
                                if (dig_ok) begin
                                    n_count = count_add;
                                end else begin
                                    n_hex = HX_DONE;
                                end
                            end
                            default: begin
                                n_hex = HX_DONE;
                            end
                        endcase
                    end
                end
                PH_DATA: begin
                    if (r_count != '0) begin
                        n_count = r_count - SIZE_BITS'(1);
                    end
                    if (r_count[SIZE_BITS-1:1] == '0) begin
                        n_phase     = PH_SKIP;
                        n_skip_left = 2'd2;
                    end
                end
                PH_SKIP: begin
                    if (r_skip_left > 2'd1) begin
                        n_skip_left = r_skip_left - 2'd1;
                    end else begin
                        n_phase     = PH_SIZE;
                        n_hex       = HX_BLANK;
                        n_count     = '0;
                        n_prev_cr   = 1'b0;
                        n_skip_left = 2'd0;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        // last byte of the request returns the parser to reset
        if (i_word.end_of_request) begin
            n_hdr_cnt   = 2'd0;
            n_in_body   = 1'b0;
            n_phase     = PH_SIZE;
            n_hex       = HX_BLANK;
            n_count     = '0;
            n_prev_cr   = 1'b0;
            n_skip_left = 2'd0;
        end
    end

    // outputs
    always_comb begin
        valid = r_in_body && (!i_mode || (r_phase == PH_DATA));
        o_result.body_byte   = valid ? b : 8'h00;
        o_result.byte_valid  = valid;
        o_result.end_of_body = i_word.end_of_request;
        o_has_result         = valid || i_word.end_of_request;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt   <= 2'd0;
            r_in_body   <= 1'b0;
            r_phase     <= PH_SIZE;
            r_hex       <= HX_BLANK;
            r_count     <= '0;
            r_prev_cr   <= 1'b0;
            r_skip_left <= 2'd0;
        end else if (i_step) begin
            r_hdr_cnt   <= n_hdr_cnt;
            r_in_body   <= n_in_body;
            r_phase     <= n_phase;
            r_hex       <= n_hex;
            r_count     <= n_count;
            r_prev_cr   <= n_prev_cr;
            r_skip_left <= n_skip_left;
        end
    end

endmodule

FILE: hw/rtl/http_body_extract_dechunk_top.sv
// http body extractor top: input register, byte parser, result register
// a result word is taken from the input register into the result register
// throughput: one byte per cycle while the result register is not stalled
// bytes that give no result leave the input register in the next cycle
// reset: synchronous, active low; clears the parser state and sets plain mode
module http_body_extract_dechunk_top #(
    parameter int SIZE_BITS = hbx_pkg::SIZE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hbx_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hbx_pkg::t_out_word             o_out_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbx_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbx_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbx_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import hbx_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      chunked_mode;
    t_out_word result;
    logic      has_result;
    logic      out_free;
    logic      advance;
    logic      accept_in;

    hbx_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_chunked_mode (chunked_mode)
    );

    hbx_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_word       (r_in_word),
        .i_mode       (chunked_mode),
        .o_result     (result),
        .o_has_result (has_result)
    );

    // handshake between the two register stages
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance && has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_word <= i_in_word;
        end
        if (advance && has_result) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // a result without a data byte only marks the end of a request
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.byte_valid) |-> o_out_word.end_of_body)
        else $error("result without data byte is not end of body");

    // a held input byte means the result register is full and stalled
    a_hold_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |-> (r_out_valid && i_out_stall))
        else $error("input stage held without a stalled result");

    // a stalled result must stay valid and unchanged until it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled result lost or changed");
`endif

endmodule
